>>> hw/rtl/olist_pkg.sv
package olist_pkg;

  // List geometry.
  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of the request and result words.
  localparam int OP_W  = 3;
  localparam int POS_W = 5;
  localparam int ST_W  = 2;
  localparam int FI_W  = 4;
  localparam int EC_W  = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             en;
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> hw/rtl/olist_cell.sv
module olist_cell (
  input  logic                           clk,
  input  olist_pkg::cell_cmd_t           cmd,
  input  logic [olist_pkg::IDX_W-1:0]    index,
  input  logic [olist_pkg::VAL_W-1:0]    lower_data,
  input  logic [olist_pkg::VAL_W-1:0]    upper_data,
  input  logic                           match_in,
  output logic [olist_pkg::VAL_W-1:0]    data,
  output logic                           match_out,
  output logic                           first
);
  import olist_pkg::*;

  logic live;
  logic hit;

  // This cell holds a valid entry when its place is below the count.
  assign live = CNT_W'(index) < cmd.count;
  assign hit  = live && (data == cmd.value);

  // The match chain tells each cell whether a lower cell already matched.
  assign match_out = match_in | hit;
  assign first     = hit & ~match_in;

  // Insert moves entries up from the lower neighbor; delete pulls them down.
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.ins) begin
        if (index == cmd.pos) begin
          data <= cmd.value;
        end else if (index > cmd.pos) begin
          data <= lower_data;
        end
      end else if (cmd.del && index >= cmd.pos) begin
        data <= upper_data;
      end
    end
  end

endmodule

>>> hw/rtl/ordered_list_insert_delete_find.sv
// A result word is registered, valid in the cycle after its request word is accepted.
// Throughput: one request word per cycle while the result side does not stall;
// every cell compares and shifts at once. Reset clears the entry count and the
// result valid flag; entry contents stay undefined until written, and no
// clearing pass is run.
module ordered_list_insert_delete_find (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [olist_pkg::OP_W-1:0]    op,
  input  logic [olist_pkg::POS_W-1:0]   position,
  input  logic [olist_pkg::VAL_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [olist_pkg::ST_W-1:0]    status,
  output logic [olist_pkg::VAL_W-1:0]   read_value,
  output logic [olist_pkg::FI_W-1:0]    found_index,
  output logic [olist_pkg::EC_W-1:0]    entry_count
);
  import olist_pkg::*;

  logic                 in_acc;
  logic [CNT_W-1:0]     used_count;
  logic [CNT_W-1:0]     used_count_next;
  logic [VAL_W-1:0]     cell_data [DEPTH];
  logic [DEPTH:0]       match_chain;
  logic [DEPTH-1:0]     first_vec;
  logic [IDX_W-1:0]     found_idx;
  cell_cmd_t            cmd;
  logic [ST_W-1:0]      st;
  logic [VAL_W-1:0]     rd;
  logic [IDX_W-1:0]     idx;
  logic                 do_ins;
  logic                 do_del;
  logic [IDX_W-1:0]     ins_pos;
  logic [IDX_W-1:0]     del_pos;
  logic                 pos_gt_cnt;
  logic                 pos_ge_cnt;

  // A new word is taken unless a finished result is held up.
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Range checks of the requested position against the count.
  assign pos_gt_cnt = 32'(position) > 32'(used_count);
  assign pos_ge_cnt = 32'(position) >= 32'(used_count);

  // Encode the one-hot first match into an index.
  always_comb begin
    found_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        found_idx = found_idx | IDX_W'(i);
      end
    end
  end

  // Decode the request into a cell command and a result.
  always_comb begin
    st      = ST_OK;
    rd      = '0;
    idx     = '0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_pos = position[IDX_W-1:0];
    del_pos = position[IDX_W-1:0];
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (op == OP_APPEND) begin
          ins_pos = used_count[IDX_W-1:0];
        end
        if (op == OP_INSERT && pos_gt_cnt) begin
          st = ST_BAD_POS;
        end else if (32'(used_count) >= DEPTH) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_ge_cnt) begin
          st = ST_BAD_POS;
        end else begin
          do_del = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_ge_cnt) begin
          st = ST_BAD_POS;
        end else begin
          rd = cell_data[position[IDX_W-1:0]];
        end
      end
      OP_FIND, OP_REMOVE: begin
        if (!match_chain[DEPTH]) begin
          st = ST_NOT_FOUND;
        end else begin
          idx = found_idx;
          if (op == OP_REMOVE) begin
            do_del  = 1'b1;
            del_pos = found_idx;
          end
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign cmd.en    = in_acc;
  assign cmd.ins   = do_ins;
  assign cmd.del   = do_del;
  assign cmd.pos   = do_ins ? ins_pos : del_pos;
  assign cmd.count = used_count;
  assign cmd.value = value;

  // Count after the request.
  always_comb begin
    used_count_next = used_count;
    if (do_ins) begin
      used_count_next = used_count + CNT_W'(1);
    end else if (do_del) begin
      used_count_next = used_count - CNT_W'(1);
    end
  end

  // The chain of cells, each handing its entry to both neighbors.
  assign match_chain[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] lower_d;
    logic [VAL_W-1:0] upper_d;
    if (g == 0) begin : g_lo_end
      assign lower_d = '0;
    end else begin : g_lo
      assign lower_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi_end
      assign upper_d = '0;
    end else begin : g_hi
      assign upper_d = cell_data[g+1];
    end
    olist_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .index      (IDX_W'(g)),
      .lower_data (lower_d),
      .upper_data (upper_d),
      .match_in   (match_chain[g]),
      .data       (cell_data[g]),
      .match_out  (match_chain[g+1]),
      .first      (first_vec[g])
    );
  end

  // Count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        used_count  <= used_count_next;
        out_valid   <= 1'b1;
        status      <= st;
        read_value  <= rd;
        found_index <= FI_W'(idx);
        entry_count <= EC_W'(used_count_next);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // The count never goes past the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(used_count) <= DEPTH)
    else $error("entry count above capacity");

  // At most one cell reports the first match.
  a_first_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first_vec))
    else $error("more than one first match");

  // A successful insert grows the list by one.
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    in_acc && do_ins |=> used_count == $past(used_count) + CNT_W'(1))
    else $error("insert did not grow the list");

  // A refused request leaves the count alone.
  a_refuse_hold: assert property (@(posedge clk) disable iff (rst)
    in_acc && st != ST_OK |=> used_count == $past(used_count))
    else $error("refused request changed the count");

  // Every accepted word yields a result word next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("result word missing");
`endif

endmodule
